@@ hw/rtl/stc_pkg.sv @@
// Shared types and constants for the sensor trend classifier.
// No dependencies.
package stc_pkg;

  localparam int unsigned JumpScale = 1000;

  typedef enum logic [2:0] {
    TrSteady   = 3'd0,
    TrRising   = 3'd1,
    TrFalling  = 3'd2,
    TrJumpUp   = 3'd3,
    TrJumpDown = 3'd4
  } trend_e;

  typedef enum logic [1:0] {
    CfgInterval = 2'd0,
    CfgWindow   = 2'd1,
    CfgTol      = 2'd2,
    CfgDeadband = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StSpan,
    StDivAbs,
    StDivRel,
    StSum,
    StOut
  } state_e;

  typedef struct packed {
    logic start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [63:0] quotient;
  } div_rsp_t;

endpackage

@@ hw/rtl/stc_divider.sv @@
// Shared signed restoring divider, one quotient bit per cycle.
// Depends on stc_pkg.
module stc_divider import stc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic        neg_q, neg_d;
  logic [63:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d;
  logic [63:0] den_q, den_d;
  logic [64:0] trial;
  logic [63:0] shifted;

  always_comb begin
    shifted = {rem_q[62:0], quo_q[63]};
    trial   = {1'b0, shifted} - {1'b0, den_q};
  end

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 7'd0;
      neg_d  = req_i.dividend[63] ^ req_i.divisor[63];
      rem_d  = '0;
      quo_d  = req_i.dividend[63] ? -req_i.dividend : req_i.dividend;
      den_d  = req_i.divisor[63] ? -req_i.divisor : req_i.divisor;
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        if (neg_q) quo_d = -quo_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

@@ hw/rtl/sensor_trend_classifier_core.sv @@
// Sensor trend classifier: takes timestamped samples newest first and
// emits closed-span records and, on the final sample, a window summary.
// Channels: sample words on sample_valid_i/sample_ready_o, result words on
// result_valid_o/result_ready_i, registers on a plain write port
// (cfg_we_i, cfg_idx_i, cfg_data_i) which the user must write only while
// idle; the block itself does not enforce this. A sample is registered on
// accept and handled in the span state; one that closes a span has its
// record registered there. A final sample adds a summary that, once the
// data set has started, needs two passes of the shared 64-bit divider,
// one quotient bit per cycle, before the summary word is registered.
// A new sample is not taken until the last one is through: sample_ready_o
// is low while an item is in work or a result word waits.
// Reset clears all data-set state and loads register defaults: interval 10,
// window 60, tolerance 65536, deadband 3277.
// A stalled receiver holds the result word and the block in place.
// Depends on stc_pkg and stc_divider.
module sensor_trend_classifier_core import stc_pkg::*; #(
  parameter int unsigned MAX_SPANS = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  input  logic        sample_valid_i,
  output logic        sample_ready_o,
  input  logic [31:0] sample_time_i,
  input  logic signed [31:0] sample_value_i,
  input  logic        final_sample_i,
  output logic        result_valid_o,
  input  logic        result_ready_i,
  output logic        result_kind_o,
  output logic [2:0]  trend_code_o,
  output logic [31:0] span_start_time_o,
  output logic [31:0] span_end_time_o,
  output logic        strictly_rising_o,
  output logic        strictly_falling_o,
  output logic        summary_valid_o,
  output logic signed [31:0] abs_pitch_q16_o,
  output logic signed [31:0] rel_pitch_q16_o,
  output logic [12:0] span_count_o,
  output logic        last_result_o
);

  localparam int unsigned CntW = $clog2(MAX_SPANS + 1);

  logic [15:0] interval_q, window_q;
  logic [23:0] tol_q, band_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= 16'd10;
      window_q   <= 16'd60;
      tol_q      <= 24'd65536;
      band_q     <= 24'd3277;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgInterval: interval_q <= cfg_data_i[15:0];
        CfgWindow:   window_q   <= cfg_data_i[15:0];
        CfgTol:      tol_q      <= cfg_data_i;
        CfgDeadband: band_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  state_e state_q, state_d;

  logic started_q, started_d;
  logic [31:0] newest_t_q, newest_t_d;
  logic signed [31:0] newest_v_q, newest_v_d;
  logic signed [33:0] bound_q, bound_d;
  logic [31:0] top_t_q, top_t_d;
  logic signed [31:0] top_v_q, top_v_d;
  logic [31:0] old_t_q, old_t_d;
  logic signed [31:0] old_v_q, old_v_d;
  logic rise_q, rise_d, fall_q, fall_d;
  logic [CntW-1:0] spans_q, spans_d;
  logic done_q, done_d;

  logic [31:0] in_t_q;
  logic signed [31:0] in_v_q;
  logic in_fin_q;

  logic signed [31:0] rel_q, rel_d;
  logic signed [31:0] abs_q, abs_d;

  logic ov_q, ov_d;
  logic ov_kind_q, ov_kind_d;
  logic [2:0] ov_code_q, ov_code_d;
  logic [31:0] ov_st_q, ov_st_d, ov_et_q, ov_et_d;
  logic ov_r_q, ov_r_d, ov_f_q, ov_f_d, ov_sv_q, ov_sv_d;
  logic signed [31:0] ov_ap_q, ov_ap_d, ov_rp_q, ov_rp_d;
  logic [12:0] ov_cnt_q, ov_cnt_d;
  logic ov_last_q, ov_last_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  stc_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  logic accept;
  assign accept         = sample_valid_i && sample_ready_o;
  assign sample_ready_o = (state_q == StIdle) && !ov_q;

  logic signed [33:0] d_diff;
  logic signed [34:0] jump_th;
  logic signed [33:0] until_t, t_ext, iv_ext;
  logic in_win, closes, proc;
  logic [2:0] code;
  logic signed [32:0] e_diff, ae;
  logic signed [33:0] dt;
  logic [31:0] sat_val;

  function automatic logic [31:0] sat64(input logic [63:0] v);
    logic pos_big, neg_big;
    begin
      pos_big = !v[63] && (v[62:31] != '0);
      neg_big = v[63] && (v[62:31] != '1);
      if (pos_big) sat64 = 32'h7fffffff;
      else if (neg_big) sat64 = 32'h80000000;
      else sat64 = v[31:0];
    end
  endfunction

  always_comb begin
    t_ext   = {2'b00, in_t_q};
    iv_ext  = {18'd0, interval_q};
    until_t = {2'b00, newest_t_q} - {18'd0, window_q};
    proc    = !done_q && (window_q != 16'd0);
    in_win  = !started_q || !(t_ext < until_t);
    closes  = proc && in_win &&
              (t_ext <= (started_q ? bound_q : t_ext - iv_ext));
    d_diff  = {{2{in_v_q[31]}}, in_v_q} -
              (started_q ? {{2{top_v_q[31]}}, top_v_q} : {{2{in_v_q[31]}}, in_v_q});
    jump_th = 35'(tol_q) * 35'(JumpScale);
    priority if (d_diff > jump_th) code = TrJumpDown;
    else if (-d_diff > jump_th) code = TrJumpUp;
    else if (d_diff > $signed({10'd0, band_q})) code = TrFalling;
    else if (-d_diff > $signed({10'd0, band_q})) code = TrRising;
    else code = TrSteady;
    e_diff = {newest_v_q[31], newest_v_q} - {old_v_q[31], old_v_q};
    ae     = e_diff[32] ? -e_diff : e_diff;
    dt     = {2'b00, newest_t_q} - {2'b00, old_t_q};
    sat_val = sat64(div_rsp.quotient);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (accept) state_d = StSpan;
      StSpan:   if (!ov_q || result_ready_i) begin
        if (!in_fin_q) state_d = StIdle;
        else if (started_d) state_d = StDivAbs;
        else state_d = StSum;
      end
      StDivAbs: if (div_rsp.done) state_d = StDivRel;
      StDivRel: if (div_rsp.done) state_d = StSum;
      StSum:    if (!ov_q || result_ready_i) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_comb begin
    started_d = started_q; newest_t_d = newest_t_q; newest_v_d = newest_v_q;
    bound_d = bound_q; top_t_d = top_t_q; top_v_d = top_v_q;
    old_t_d = old_t_q; old_v_d = old_v_q; rise_d = rise_q; fall_d = fall_q;
    spans_d = spans_q; done_d = done_q; rel_d = rel_q; abs_d = abs_q;
    ov_d = ov_q && !result_ready_i;
    ov_kind_d = ov_kind_q; ov_code_d = ov_code_q; ov_st_d = ov_st_q;
    ov_et_d = ov_et_q; ov_r_d = ov_r_q; ov_f_d = ov_f_q; ov_sv_d = ov_sv_q;
    ov_ap_d = ov_ap_q; ov_rp_d = ov_rp_q; ov_cnt_d = ov_cnt_q;
    ov_last_d = ov_last_q;
    div_req = '0;
    unique case (state_q)
      StSpan: if (!ov_q || result_ready_i) begin
        if (proc) begin
          if (!in_win) begin
            done_d = 1'b1;
          end else begin
            if (!started_q) begin
              started_d  = 1'b1;
              newest_t_d = in_t_q;
              newest_v_d = in_v_q;
            end
            old_t_d = in_t_q;
            old_v_d = in_v_q;
            if (!started_q) begin
              top_t_d = in_t_q;
              top_v_d = in_v_q;
              bound_d = t_ext - iv_ext;
            end
            if (closes) begin
              ov_d      = 1'b1;
              ov_kind_d = 1'b0;
              ov_code_d = code;
              ov_st_d   = in_t_q;
              ov_et_d   = started_q ? top_t_q : in_t_q;
              ov_r_d    = rise_q && !(code == TrFalling || code == TrJumpDown);
              ov_f_d    = fall_q && !(code == TrRising || code == TrJumpUp);
              rise_d    = ov_r_d;
              fall_d    = ov_f_d;
              if (spans_q < CntW'(MAX_SPANS)) spans_d = spans_q + 1'b1;
              ov_cnt_d  = 13'(spans_d);
              ov_sv_d   = 1'b0;
              ov_ap_d   = '0;
              ov_rp_d   = '0;
              ov_last_d = !in_fin_q;
              top_t_d   = in_t_q;
              top_v_d   = in_v_q;
              bound_d   = t_ext - iv_ext;
            end
          end
        end
        if (in_fin_q && (started_d)) begin
          div_req.start    = 1'b1;
          div_req.dividend = 64'(signed'({newest_v_d[31], newest_v_d} -
                                         {old_v_d[31], old_v_d}));
          div_req.divisor  = 64'(signed'({2'b00, newest_t_d} - {2'b00, old_t_d}));
        end
      end
      StDivAbs: if (div_rsp.done) begin
        abs_d = (dt == '0) ? 32'sd0 : $signed(sat_val);
        div_req.start    = 1'b1;
        div_req.dividend = 64'(-e_diff);
        div_req.divisor  = 64'(spans_q);
      end
      StDivRel: if (div_rsp.done) begin
        rel_d = (spans_q == '0) ? 32'sd0 : $signed(sat_val);
      end
      StSum: if (!ov_q || result_ready_i) begin
        ov_d      = 1'b1;
        ov_kind_d = 1'b1;
        ov_last_d = 1'b1;
        ov_code_d = TrSteady;
        ov_st_d = '0; ov_et_d = '0; ov_r_d = 1'b0; ov_f_d = 1'b0;
        ov_sv_d = 1'b0; ov_ap_d = '0; ov_cnt_d = '0;
        if (started_q) begin
          if ({ae[31:0], 1'b0} > {1'b0, 9'd0, tol_q} && !ae[32])
            ov_code_d = e_diff[32] ? TrFalling : TrRising;
          else if (ae[32])
            ov_code_d = e_diff[32] ? TrFalling : TrRising;
          ov_st_d  = old_t_q;
          ov_et_d  = newest_t_q;
          ov_r_d   = rise_q;
          ov_f_d   = fall_q;
          ov_sv_d  = 1'b1;
          ov_ap_d  = abs_q;
          ov_rp_d  = rel_q;
          ov_cnt_d = 13'(spans_q);
        end else begin
          ov_rp_d = '0;
        end
        started_d = 1'b0; newest_t_d = '0; newest_v_d = '0; bound_d = '0;
        top_t_d = '0; top_v_d = '0; old_t_d = '0; old_v_d = '0;
        rise_d = 1'b1; fall_d = 1'b1; spans_d = '0; done_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      started_q <= 1'b0; newest_t_q <= '0; newest_v_q <= '0; bound_q <= '0;
      top_t_q <= '0; top_v_q <= '0; old_t_q <= '0; old_v_q <= '0;
      rise_q <= 1'b1; fall_q <= 1'b1; spans_q <= '0; done_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      started_q <= started_d; newest_t_q <= newest_t_d; newest_v_q <= newest_v_d;
      bound_q <= bound_d; top_t_q <= top_t_d; top_v_q <= top_v_d;
      old_t_q <= old_t_d; old_v_q <= old_v_d; rise_q <= rise_d; fall_q <= fall_d;
      spans_q <= spans_d; done_q <= done_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_t_q   <= sample_time_i;
      in_v_q   <= sample_value_i;
      in_fin_q <= final_sample_i;
    end
    abs_q <= abs_d;
    rel_q <= rel_d;
    ov_kind_q <= ov_kind_d; ov_code_q <= ov_code_d; ov_st_q <= ov_st_d;
    ov_et_q <= ov_et_d; ov_r_q <= ov_r_d; ov_f_q <= ov_f_d; ov_sv_q <= ov_sv_d;
    ov_ap_q <= ov_ap_d; ov_rp_q <= ov_rp_d; ov_cnt_q <= ov_cnt_d;
    ov_last_q <= ov_last_d;
  end

  assign result_valid_o     = ov_q;
  assign result_kind_o      = ov_kind_q;
  assign trend_code_o       = ov_code_q;
  assign span_start_time_o  = ov_st_q;
  assign span_end_time_o    = ov_et_q;
  assign strictly_rising_o  = ov_r_q;
  assign strictly_falling_o = ov_f_q;
  assign summary_valid_o    = ov_sv_q;
  assign abs_pitch_q16_o    = ov_ap_q;
  assign rel_pitch_q16_o    = ov_rp_q;
  assign span_count_o       = ov_cnt_q;
  assign last_result_o      = ov_last_q;

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for sensor_trend_classifier_core: predicts span
// records and window summaries per sample word and compares every result word.
// Depends on stc_pkg and the core RTL.
module tb;
  import stc_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [2:0]  code;
    logic [31:0] t_start;
    logic [31:0] t_end;
    logic        rising;
    logic        falling;
    logic        valid;
    logic [31:0] abs_p;
    logic [31:0] rel_p;
    logic [12:0] count;
    logic        last;
  } trend_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [23:0] cfg_data_i = '0;
  logic sample_valid_i = 1'b0;
  logic sample_ready_o;
  logic [31:0] sample_time_i = '0;
  logic signed [31:0] sample_value_i = '0;
  logic final_sample_i = 1'b0;
  logic result_valid_o;
  logic result_ready_i = 1'b0;
  logic result_kind_o;
  logic [2:0] trend_code_o;
  logic [31:0] span_start_time_o, span_end_time_o;
  logic strictly_rising_o, strictly_falling_o, summary_valid_o;
  logic signed [31:0] abs_pitch_q16_o, rel_pitch_q16_o;
  logic [12:0] span_count_o;
  logic last_result_o;

  sensor_trend_classifier_core dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  longint unsigned m_interval, m_window, m_tol, m_band;
  bit m_started, m_done, m_rise, m_fall;
  longint m_new_t, m_new_v, m_bound, m_top_t, m_top_v, m_old_t, m_old_v;
  longint unsigned m_spans;

  trend_word_t expected_words[$];
  int errors = 0;
  int words_seen = 0;
  int items_sent = 0;
  int summaries = 0;
  longint unsigned cycles = 0;
  longint unsigned limit = 64'd4_000_000;
  logic [31:0] seq_time;

  function automatic void clear_set();
    m_started = 0; m_done = 0; m_rise = 1; m_fall = 1;
    m_new_t = 0; m_new_v = 0; m_bound = 0; m_top_t = 0; m_top_v = 0;
    m_old_t = 0; m_old_v = 0; m_spans = 0;
  endfunction

  function automatic logic [31:0] sat32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic trend_e classify_span(longint older, longint newer);
    longint d, jump, band;
    d = older - newer;
    jump = longint'(m_tol) * JumpScale;
    band = longint'(m_band);
    if (d > jump) return TrJumpDown;
    if (-d > jump) return TrJumpUp;
    if (d > band) return TrFalling;
    if (-d > band) return TrRising;
    return TrSteady;
  endfunction

  function automatic void predict_trend(logic [31:0] t_in, logic signed [31:0] v_in,
                                        logic fin);
    longint t, v, e, ae, dt;
    trend_e code;
    trend_word_t w;
    t = longint'(t_in);
    v = longint'(v_in);
    if (!m_done && m_window != 0) begin
      if (m_started && t < m_new_t - longint'(m_window)) begin
        m_done = 1;
      end else begin
        if (!m_started) begin
          m_started = 1; m_new_t = t; m_new_v = v; m_top_t = t; m_top_v = v;
          m_bound = t - longint'(m_interval);
        end
        m_old_t = t; m_old_v = v;
        if (t <= m_bound) begin
          code = classify_span(v, m_top_v);
          if (code == TrRising || code == TrJumpUp) m_fall = 0;
          if (code == TrFalling || code == TrJumpDown) m_rise = 0;
          if (m_spans < 4096) m_spans++;
          w = '0;
          w.code = code; w.t_start = t_in; w.t_end = m_top_t[31:0];
          w.rising = m_rise; w.falling = m_fall; w.count = m_spans[12:0];
          w.last = !fin;
          expected_words.push_back(w);
          m_top_t = t; m_top_v = v; m_bound = t - longint'(m_interval);
        end
      end
    end
    if (fin) begin
      w = '0;
      w.kind = 1; w.last = 1;
      if (m_started) begin
        e = m_new_v - m_old_v;
        ae = e < 0 ? -e : e;
        dt = m_new_t - m_old_t;
        if (2 * ae > longint'(m_tol)) w.code = e > 0 ? TrRising : TrFalling;
        else w.code = TrSteady;
        w.t_start = m_old_t[31:0]; w.t_end = m_new_t[31:0];
        w.rising = m_rise; w.falling = m_fall; w.valid = 1;
        w.abs_p = dt != 0 ? sat32(e / dt) : '0;
        w.rel_p = m_spans != 0 ? sat32((-e) / longint'(m_spans)) : '0;
        w.count = m_spans[12:0];
      end
      expected_words.push_back(w);
      summaries++;
      clear_set();
    end
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > limit) begin
      $display("%0t timeout", $time);
      $display("tb: errors");
      $finish;
    end
  end

  // receiver: random stalls, checks each word against the oldest expectation
  initial begin : receiver
    int gap;
    trend_word_t got, exp_w;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
        result_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      result_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!result_valid_o) @(posedge clk_i);
      got = {result_kind_o, trend_code_o, span_start_time_o, span_end_time_o,
             strictly_rising_o, strictly_falling_o, summary_valid_o,
             abs_pitch_q16_o, rel_pitch_q16_o, span_count_o, last_result_o};
      words_seen++;
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t unexpected result word %h", $time, got);
      end else begin
        exp_w = expected_words.pop_front();
        if (got !== exp_w) begin
          errors++;
          $display("%0t mismatch exp kind=%0d code=%0d st=%0d en=%0d r=%0d f=%0d v=%0d",
                   $time, exp_w.kind, exp_w.code, exp_w.t_start, exp_w.t_end,
                   exp_w.rising, exp_w.falling, exp_w.valid);
          $display("     exp abs=%0d rel=%0d cnt=%0d last=%0d", $signed(exp_w.abs_p),
                   $signed(exp_w.rel_p), exp_w.count, exp_w.last);
          $display("     got kind=%0d code=%0d st=%0d en=%0d r=%0d f=%0d v=%0d",
                   got.kind, got.code, got.t_start, got.t_end, got.rising,
                   got.falling, got.valid);
          $display("     got abs=%0d rel=%0d cnt=%0d last=%0d", $signed(got.abs_p),
                   $signed(got.rel_p), got.count, got.last);
        end
      end
    end
  end

  task automatic send_sample(logic [31:0] t, logic signed [31:0] v, logic fin);
    int gap;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      sample_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    predict_trend(t, v, fin);
    sample_valid_i <= 1'b1;
    sample_time_i <= t;
    sample_value_i <= v;
    final_sample_i <= fin;
    @(posedge clk_i);
    while (!sample_ready_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic wait_drain();
    sample_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [23:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CfgInterval: m_interval = val[15:0];
      CfgWindow:   m_window = val[15:0];
      CfgTol:      m_tol = val;
      default:     m_band = val;
    endcase
  endtask

  task automatic set_regs(logic [15:0] iv, logic [15:0] wn, logic [23:0] tl,
                          logic [23:0] db);
    wait_drain();
    write_reg(CfgInterval, {8'd0, iv});
    write_reg(CfgWindow, {8'd0, wn});
    write_reg(CfgTol, tl);
    write_reg(CfgDeadband, db);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_defaults();
    send_sample(32'd1000, 32'sd0, 1'b0);
    send_sample(32'd995, 32'sd1000, 1'b0);
    send_sample(32'd990, 32'sd5000, 1'b0);
    send_sample(32'd980, -32'sd5000, 1'b0);
    send_sample(32'd970, 32'sd70000000, 1'b0);
    send_sample(32'd960, -32'sd80000000, 1'b0);
    send_sample(32'd950, -32'sd80000100, 1'b0);
    send_sample(32'd930, 32'sd7, 1'b0);
    send_sample(32'd900, 32'sd9, 1'b1);
  endtask

  task automatic test_extremes();
    set_regs(16'd1, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_sample(32'hFFFFFFFF, 32'sh7FFFFFFF, 1'b0);
    send_sample(32'hFFFFFFF0, 32'sh80000000, 1'b0);
    send_sample(32'hFFFF0000, 32'sh7FFFFFFF, 1'b1);
    set_regs(16'd0, 16'd5, 24'd0, 24'd0);
    send_sample(32'd20, 32'sh7FFFFFFF, 1'b0);
    send_sample(32'd20, 32'sh80000000, 1'b0);
    send_sample(32'd18, 32'sd1, 1'b0);
    send_sample(32'd2, 32'sd5, 1'b0);
    send_sample(32'd1, 32'sd5, 1'b1);
    send_sample(32'd0, 32'sh80000000, 1'b1);
    set_regs(16'd3, 16'd0, 24'd10, 24'd1);
    send_sample(32'd50, 32'sd100, 1'b0);
    send_sample(32'd40, 32'sd1, 1'b1);
    set_regs(16'hFFFF, 16'd100, 24'd1, 24'd0);
    send_sample(32'd5, -32'sd3, 1'b0);
    send_sample(32'd9, 32'sd3, 1'b1);
  endtask

  task automatic run_random_sets(int n_items);
    int len, i;
    logic signed [31:0] v;
    while (n_items > 0) begin
      len = $urandom_range(1, 12);
      seq_time = $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 100000);
      v = $urandom;
      for (i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0) v = $urandom;
        else v = v + $signed($urandom_range(0, 200000)) - 100000;
        send_sample(seq_time, v, i == len - 1);
        if ($urandom_range(0, 9) == 0) seq_time = seq_time + $urandom_range(0, 5);
        else seq_time = seq_time - $urandom_range(0, 32'(3 * m_interval + 2));
      end
      n_items -= len;
    end
  endtask

  task automatic test_random();
    int p;
    for (p = 0; p < 8; p++) begin
      case (p)
        0: set_regs(16'd10, 16'd60, 24'd65536, 24'd3277);
        1: set_regs(16'd1, 16'd20, 24'd50, 24'd20000);
        2: set_regs(16'd0, 16'd8, 24'd0, 24'd0);
        3: set_regs(16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
        default: set_regs(16'($urandom_range(0, 12)), 16'($urandom_range(0, 40)),
                          24'($urandom_range(0, 300)), 24'($urandom_range(0, 100000)));
      endcase
      run_random_sets(105);
    end
  endtask

  initial begin
    m_interval = 10; m_window = 60; m_tol = 65536; m_band = 3277;
    clear_set();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_extremes();
    test_random();
    wait_drain();
    $display("tb: %0d samples in, %0d result words checked, %0d summaries",
             items_sent, words_seen, summaries);
    if (errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end
endmodule

@@ files.f @@
hw/rtl/stc_pkg.sv
hw/rtl/stc_divider.sv
hw/rtl/sensor_trend_classifier_core.sv
dv/tb.sv
